// ===== src/mhap_pkg.sv =====
`timescale 1ns / 1ps

package mhap_pkg;

  // addressing mode codes (frame control bits 11:10 and 15:14)
  localparam logic [1:0] MODE_NONE     = 2'd0;
  localparam logic [1:0] MODE_RESERVED = 2'd1;
  localparam logic [1:0] MODE_SHORT    = 2'd2;
  localparam logic [1:0] MODE_EXT      = 2'd3;

  // result error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_DEST_MODE = 2'd1;
  localparam logic [1:0] ERR_SRC_MODE  = 2'd2;

  // header layout
  localparam logic [4:0] SEQ_END   = 5'd3;
  localparam logic [4:0] SHORT_LEN = 5'd2;
  localparam logic [4:0] EXT_LEN   = 5'd8;
  localparam logic [4:0] PAN_LEN   = 5'd2;

  // one frame byte as it travels from the input register to the parser
  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } mhap_beat_t;

  // one parse result
  typedef struct packed {
    logic [1:0]  dest_mode;
    logic [15:0] dest_pan_id;
    logic [15:0] dest_short_addr;
    logic [63:0] dest_ext_addr;
    logic [1:0]  src_mode;
    logic [15:0] src_pan_id;
    logic [15:0] src_short_addr;
    logic [63:0] src_ext_addr;
    logic [4:0]  header_length;
    logic [1:0]  error_code;
  } mhap_result_t;

endpackage

// ===== src/mhap_input_stage.sv =====
`timescale 1ns / 1ps

module mhap_input_stage
  import mhap_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       frame_start,
  input  logic       advance,
  output logic       beat_valid,
  output mhap_beat_t beat
);

  logic beat_valid_next;

  assign in_ready = !beat_valid || advance;

  always_comb begin
    beat_valid_next = beat_valid;
    if (in_valid && in_ready) begin
      beat_valid_next = 1'b1;
    end else if (advance) begin
      beat_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else begin
      beat_valid <= beat_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat.data  <= data_byte;
      beat.start <= frame_start;
    end
  end

endmodule

// ===== src/mhap_field_parser.sv =====
`timescale 1ns / 1ps

module mhap_field_parser
  import mhap_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  mhap_beat_t   beat,
  output logic         result_valid,
  output mhap_result_t result
);

  logic [4:0]  byte_position, byte_position_next;
  logic        parse_active, parse_active_next;
  logic [15:0] control_word, control_word_next;
  logic [15:0] dest_pan_reg, dest_pan_reg_next;
  logic [63:0] dest_addr_reg, dest_addr_reg_next;
  logic [15:0] src_pan_reg, src_pan_reg_next;
  logic [63:0] src_addr_reg, src_addr_reg_next;

  logic        cur_active;
  logic [4:0]  base_pos;
  logic [15:0] base_cw, cw_full;
  logic [15:0] base_dpan, base_span;
  logic [63:0] base_daddr, base_saddr;
  logic [1:0]  dmode, smode;
  logic        comp;
  logic [4:0]  dlen, slen, span_len;
  logic [4:0]  daddr_at, span_at, saddr_at, hdr_len;
  logic [15:0] dpan_cap, span_cap;
  logic [63:0] daddr_cap, saddr_cap;

  function automatic logic [4:0] addr_len(input logic [1:0] mode);
    logic [4:0] len;
    len = 5'd0;
    if (mode == MODE_SHORT) len = SHORT_LEN;
    if (mode == MODE_EXT) len = EXT_LEN;
    return len;
  endfunction

  // drop byte b into lane (pos - start) when pos falls inside the field
  function automatic logic [63:0] take_byte(input logic [63:0] value,
                                            input logic [4:0] start,
                                            input logic [4:0] len,
                                            input logic [4:0] pos,
                                            input logic [7:0] b);
    logic [63:0] res;
    logic [4:0]  off;
    res = value;
    off = pos - start;
    if (pos >= start && pos < 5'(start + len)) begin
      for (int i = 0; i < 8; i++) begin
        if (off[2:0] == 3'(i)) res[i*8 +: 8] = b;
      end
    end
    return res;
  endfunction

  // a frame start wipes the partial parse before this byte is used
  assign cur_active = beat.start || parse_active;
  assign base_pos   = beat.start ? 5'd0  : byte_position;
  assign base_cw    = beat.start ? 16'd0 : control_word;
  assign base_dpan  = beat.start ? 16'd0 : dest_pan_reg;
  assign base_span  = beat.start ? 16'd0 : src_pan_reg;
  assign base_daddr = beat.start ? 64'd0 : dest_addr_reg;
  assign base_saddr = beat.start ? 64'd0 : src_addr_reg;

  assign cw_full = (base_pos == 5'd1) ? {beat.data, base_cw[7:0]} : base_cw;
  assign dmode   = cw_full[11:10];
  assign smode   = cw_full[15:14];
  assign comp    = cw_full[6];

  assign dlen     = addr_len(dmode);
  assign slen     = addr_len(smode);
  assign daddr_at = SEQ_END + ((dmode != MODE_NONE) ? PAN_LEN : 5'd0);
  assign span_at  = daddr_at + dlen;
  assign span_len = (smode != MODE_NONE && !comp) ? PAN_LEN : 5'd0;
  assign saddr_at = span_at + span_len;
  assign hdr_len  = saddr_at + slen;

  assign dpan_cap  = (dmode != MODE_NONE)
                     ? 16'(take_byte({48'd0, base_dpan}, SEQ_END, PAN_LEN, base_pos,
                                     beat.data))
                     : base_dpan;
  assign daddr_cap = (dmode != MODE_NONE)
                     ? take_byte(base_daddr, daddr_at, dlen, base_pos, beat.data)
                     : base_daddr;
  assign span_cap  = 16'(take_byte({48'd0, base_span}, span_at, span_len, base_pos,
                                   beat.data));
  assign saddr_cap = take_byte(base_saddr, saddr_at, slen, base_pos, beat.data);

  always_comb begin
    byte_position_next = byte_position;
    parse_active_next  = parse_active;
    control_word_next  = control_word;
    dest_pan_reg_next  = dest_pan_reg;
    dest_addr_reg_next = dest_addr_reg;
    src_pan_reg_next   = src_pan_reg;
    src_addr_reg_next  = src_addr_reg;
    result_valid       = 1'b0;
    result             = '0;
    if (step && cur_active) begin
      parse_active_next  = 1'b1;
      control_word_next  = base_cw;
      dest_pan_reg_next  = base_dpan;
      dest_addr_reg_next = base_daddr;
      src_pan_reg_next   = base_span;
      src_addr_reg_next  = base_saddr;
      if (base_pos == 5'd0) begin
        control_word_next  = {8'd0, beat.data};
        byte_position_next = 5'd1;
      end else if (base_pos == 5'd1) begin
        control_word_next = cw_full;
        if (dmode == MODE_RESERVED || smode == MODE_RESERVED) begin
          result_valid       = 1'b1;
          result.dest_mode   = dmode;
          result.src_mode    = smode;
          result.error_code  = (dmode == MODE_RESERVED) ? ERR_DEST_MODE : ERR_SRC_MODE;
          parse_active_next  = 1'b0;
          byte_position_next = 5'd0;
        end else begin
          byte_position_next = 5'd2;
        end
      end else begin
        dest_pan_reg_next  = dpan_cap;
        dest_addr_reg_next = daddr_cap;
        src_pan_reg_next   = span_cap;
        src_addr_reg_next  = saddr_cap;
        if (5'(base_pos + 5'd1) < hdr_len) begin
          byte_position_next = 5'(base_pos + 5'd1);
        end else begin
          result_valid           = 1'b1;
          result.dest_mode       = dmode;
          result.dest_pan_id     = (dmode != MODE_NONE) ? dpan_cap : 16'd0;
          result.dest_short_addr = (dmode == MODE_SHORT) ? daddr_cap[15:0] : 16'd0;
          result.dest_ext_addr   = (dmode == MODE_EXT) ? daddr_cap : 64'd0;
          result.src_mode        = smode;
          if (smode != MODE_NONE) begin
            if (comp) begin
              result.src_pan_id = (dmode != MODE_NONE) ? dpan_cap : 16'd0;
            end else begin
              result.src_pan_id = span_cap;
            end
          end
          result.src_short_addr  = (smode == MODE_SHORT) ? saddr_cap[15:0] : 16'd0;
          result.src_ext_addr    = (smode == MODE_EXT) ? saddr_cap : 64'd0;
          result.header_length   = hdr_len;
          result.error_code      = ERR_NONE;
          parse_active_next      = 1'b0;
          byte_position_next     = 5'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 5'd0;
      parse_active  <= 1'b0;
      control_word  <= 16'd0;
      dest_pan_reg  <= 16'd0;
      dest_addr_reg <= 64'd0;
      src_pan_reg   <= 16'd0;
      src_addr_reg  <= 64'd0;
    end else begin
      byte_position <= byte_position_next;
      parse_active  <= parse_active_next;
      control_word  <= control_word_next;
      dest_pan_reg  <= dest_pan_reg_next;
      dest_addr_reg <= dest_addr_reg_next;
      src_pan_reg   <= src_pan_reg_next;
      src_addr_reg  <= src_addr_reg_next;
    end
  end

`ifndef SYNTHESIS
  // a result always ends the frame
  a_result_goes_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !parse_active && byte_position == 5'd0)
    else $error("parser still active after a result");

  // idle parser never sits mid-header
  a_idle_at_zero: assert property (@(posedge clk) disable iff (rst)
    !parse_active |-> byte_position == 5'd0)
    else $error("idle parser with nonzero byte position");
`endif

endmodule

// ===== src/mhap_output_stage.sv =====
`timescale 1ns / 1ps

module mhap_output_stage
  import mhap_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  mhap_result_t result_in,
  input  logic         out_ready,
  output logic         out_valid,
  output mhap_result_t result
);

  logic out_valid_next;

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_in;
    end
  end

endmodule

// ===== src/mac_header_address_parser_unit.sv =====
`timescale 1ns / 1ps

// 802.15.4 mac header address field parser
//
// input channel: one frame byte per beat on data_byte, with frame_start set on
// the first byte of each frame (in_valid / in_ready). bytes that arrive while
// no frame is open are dropped. a new frame_start discards any partial parse.
//
// output channel: at most one result beat per frame (out_valid / out_ready)
// carrying both addressing modes, pan ids, short and extended addresses,
// header length and an error code. a reserved mode ends the frame right after
// the second control byte with only the modes and the error code filled in.
//
// timing: a byte is captured in the input register, then parsed into the
// output register once that register can take a result, so out_valid rises
// after the last header byte has passed through both registers. throughput is
// one byte per cycle while no result waits on out_ready, set by the
// combinational field capture between the two registers.
//
// reset (rst, synchronous) empties both registers and returns the parser to
// idle. while out_ready holds a waiting result, any byte in the input register
// waits too, and in_ready drops once that register is full.

module mac_header_address_parser_unit
  import mhap_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  dest_mode,
  output logic [15:0] dest_pan_id,
  output logic [15:0] dest_short_addr,
  output logic [63:0] dest_ext_addr,
  output logic [1:0]  src_mode,
  output logic [15:0] src_pan_id,
  output logic [15:0] src_short_addr,
  output logic [63:0] src_ext_addr,
  output logic [4:0]  header_length,
  output logic [1:0]  error_code
);

  logic         beat_valid;
  mhap_beat_t   beat;
  logic         advance;
  logic         result_valid;
  mhap_result_t parse_result;
  mhap_result_t result;

  // the byte in the input register moves on whenever the output register can
  // take a result this cycle (empty or being drained)
  assign advance = beat_valid && (!out_valid || out_ready);

  mhap_input_stage u_input (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .advance     (advance),
    .beat_valid  (beat_valid),
    .beat        (beat)
  );

  // frame state and field capture, one byte per step
  mhap_field_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .beat         (beat),
    .result_valid (result_valid),
    .result       (parse_result)
  );

  mhap_output_stage u_output (
    .clk       (clk),
    .rst       (rst),
    .load      (result_valid),
    .result_in (parse_result),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .result    (result)
  );

  // unpack the result register onto the field ports
  assign dest_mode       = result.dest_mode;
  assign dest_pan_id     = result.dest_pan_id;
  assign dest_short_addr = result.dest_short_addr;
  assign dest_ext_addr   = result.dest_ext_addr;
  assign src_mode        = result.src_mode;
  assign src_pan_id      = result.src_pan_id;
  assign src_short_addr  = result.src_short_addr;
  assign src_ext_addr    = result.src_ext_addr;
  assign header_length   = result.header_length;
  assign error_code      = result.error_code;

`ifndef SYNTHESIS
  // error results carry no header length
  a_err_no_length: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != ERR_NONE |-> header_length == 5'd0)
    else $error("error result with nonzero header length");

  // good results cover at least control word and sequence number
  a_ok_min_length: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code == ERR_NONE |-> header_length >= SEQ_END)
    else $error("good result shorter than minimum header");

  // absent destination leaves its fields at zero
  a_no_dest_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && dest_mode == MODE_NONE |-> dest_pan_id == 16'd0 &&
      dest_short_addr == 16'd0 && dest_ext_addr == 64'd0)
    else $error("destination fields set with no destination");

  // the parser never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !out_valid || out_ready)
    else $error("result produced while output register is held");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb
  import mhap_pkg::*;
;

  // one byte waiting in the sender queue
  typedef struct {
    logic [7:0] data;
    logic       start;
    logic       drain;  // hold this beat back until every pending result is out
  } frame_byte_t;

  localparam int ITEM_TARGET      = 1750;
  localparam int STALL_LIMIT      = 3000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES      = 20;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        frame_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  dest_mode;
  logic [15:0] dest_pan_id;
  logic [15:0] dest_short_addr;
  logic [63:0] dest_ext_addr;
  logic [1:0]  src_mode;
  logic [15:0] src_pan_id;
  logic [15:0] src_short_addr;
  logic [63:0] src_ext_addr;
  logic [4:0]  header_length;
  logic [1:0]  error_code;

  mac_header_address_parser_unit u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .frame_start     (frame_start),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .dest_mode       (dest_mode),
    .dest_pan_id     (dest_pan_id),
    .dest_short_addr (dest_short_addr),
    .dest_ext_addr   (dest_ext_addr),
    .src_mode        (src_mode),
    .src_pan_id      (src_pan_id),
    .src_short_addr  (src_short_addr),
    .src_ext_addr    (src_ext_addr),
    .header_length   (header_length),
    .error_code      (error_code)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  frame_byte_t  byte_q[$];
  mhap_result_t header_exp_q[$];
  int           n_total;
  int           n_sent;
  int           n_mismatch;
  int           stall_cnt;

  // shadow parser state
  logic [4:0]  hdr_pos;
  logic        hdr_open;
  logic [15:0] fc_word;
  logic [15:0] dpan_acc;
  logic [63:0] daddr_acc;
  logic [15:0] span_acc;
  logic [63:0] saddr_acc;

  function automatic logic [4:0] addr_bytes(logic [1:0] mode);
    case (mode)
      MODE_SHORT: return SHORT_LEN;
      MODE_EXT:   return EXT_LEN;
      default:    return 5'd0;
    endcase
  endfunction

  // bytes from the first control byte through the last address byte
  function automatic logic [4:0] header_bytes(logic [15:0] fc);
    logic [1:0] dm;
    logic [1:0] sm;
    dm = fc[11:10];
    sm = fc[15:14];
    return SEQ_END + ((dm != MODE_NONE) ? PAN_LEN : 5'd0) + addr_bytes(dm)
           + ((sm != MODE_NONE && !fc[6]) ? PAN_LEN : 5'd0) + addr_bytes(sm);
  endfunction

  // advance the shadow parser by one accepted beat, queue a result if one is due
  function void parse_header_byte(logic [7:0] b, logic st);
    logic [1:0]   dm;
    logic [1:0]   sm;
    logic         comp;
    logic [4:0]   daddr_at;
    logic [4:0]   span_at;
    logic [4:0]   saddr_at;
    logic [4:0]   hlen;
    mhap_result_t r;
    if (st) begin
      hdr_pos   = 5'd0;
      fc_word   = '0;
      dpan_acc  = '0;
      daddr_acc = '0;
      span_acc  = '0;
      saddr_acc = '0;
      hdr_open  = 1'b1;
    end
    if (!hdr_open) return;
    if (hdr_pos == 5'd0) begin
      fc_word[7:0] = b;
      hdr_pos = 5'd1;
      return;
    end
    if (hdr_pos == 5'd1) fc_word[15:8] = b;
    dm   = fc_word[11:10];
    sm   = fc_word[15:14];
    comp = fc_word[6];
    r    = '0;
    if (hdr_pos == 5'd1) begin
      // a reserved mode ends the frame here, dest error wins
      if (dm == MODE_RESERVED || sm == MODE_RESERVED) begin
        r.dest_mode  = dm;
        r.src_mode   = sm;
        r.error_code = (dm == MODE_RESERVED) ? ERR_DEST_MODE : ERR_SRC_MODE;
        header_exp_q.push_back(r);
        hdr_open = 1'b0;
        hdr_pos  = 5'd0;
      end else begin
        hdr_pos = 5'd2;
      end
      return;
    end
    daddr_at = SEQ_END + ((dm != MODE_NONE) ? PAN_LEN : 5'd0);
    span_at  = daddr_at + addr_bytes(dm);
    saddr_at = span_at + ((sm != MODE_NONE && !comp) ? PAN_LEN : 5'd0);
    hlen     = saddr_at + addr_bytes(sm);
    if (dm != MODE_NONE && hdr_pos >= SEQ_END && hdr_pos < daddr_at)
      dpan_acc[8*(hdr_pos-SEQ_END) +: 8] = b;
    if (hdr_pos >= daddr_at && hdr_pos < span_at)
      daddr_acc[8*(hdr_pos-daddr_at) +: 8] = b;
    if (hdr_pos >= span_at && hdr_pos < saddr_at)
      span_acc[8*(hdr_pos-span_at) +: 8] = b;
    if (hdr_pos >= saddr_at && hdr_pos < hlen)
      saddr_acc[8*(hdr_pos-saddr_at) +: 8] = b;
    if (hdr_pos + 5'd1 < hlen) begin
      hdr_pos = hdr_pos + 5'd1;
      return;
    end
    r.dest_mode       = dm;
    r.dest_pan_id     = (dm != MODE_NONE) ? dpan_acc : 16'd0;
    r.dest_short_addr = (dm == MODE_SHORT) ? daddr_acc[15:0] : 16'd0;
    r.dest_ext_addr   = (dm == MODE_EXT) ? daddr_acc : 64'd0;
    r.src_mode        = sm;
    // under compression the source pan id mirrors the dest one (zero if no dest)
    if (sm != MODE_NONE)
      r.src_pan_id = comp ? ((dm != MODE_NONE) ? dpan_acc : 16'd0) : span_acc;
    r.src_short_addr  = (sm == MODE_SHORT) ? saddr_acc[15:0] : 16'd0;
    r.src_ext_addr    = (sm == MODE_EXT) ? saddr_acc : 64'd0;
    r.header_length   = hlen;
    r.error_code      = ERR_NONE;
    header_exp_q.push_back(r);
    hdr_open = 1'b0;
    hdr_pos  = 5'd0;
  endfunction

  function void queue_byte(logic [7:0] d, logic s, logic dr);
    frame_byte_t fb;
    fb.data  = d;
    fb.start = s;
    fb.drain = dr;
    byte_q.push_back(fb);
  endfunction

  // one frame header, sometimes cut short, sometimes followed by payload bytes
  task automatic add_frame(logic [15:0] fc, bit drain);
    int n;
    int keep;
    int i;
    if (fc[11:10] == MODE_RESERVED || fc[15:14] == MODE_RESERVED) n = 2;
    else n = int'(header_bytes(fc));
    keep = n;
    if ($urandom_range(99) < 8) keep = int'($urandom_range(n - 1, 1));
    queue_byte(fc[7:0], 1'b1, drain);
    if (keep > 1) queue_byte(fc[15:8], 1'b0, 1'b0);
    for (i = 2; i < keep; i++) queue_byte(8'($urandom), 1'b0, 1'b0);
    if ($urandom_range(99) < 30)
      repeat ($urandom_range(4, 1)) queue_byte(8'($urandom), 1'b0, 1'b0);
  endtask

  function automatic logic [1:0] pick_mode();
    int r;
    r = int'($urandom_range(99));
    if (r < 6) return MODE_RESERVED;
    if (r < 37) return MODE_NONE;
    if (r < 68) return MODE_SHORT;
    return MODE_EXT;
  endfunction

  function int tx_idle_pct();
    if (n_sent < n_total / 3) return 22;
    if (n_sent < 2 * n_total / 3) return 68;
    return 0;
  endfunction

  function int rx_idle_pct();
    if (n_sent < n_total / 3) return 68;
    if (n_sent < 2 * n_total / 3) return 22;
    return 0;
  endfunction

  function void check_field(string name, logic [63:0] e, logic [63:0] a);
    if (a !== e) begin
      n_mismatch++;
      if (n_mismatch <= 10)
        $display("mismatch on %s: expected %h, got %h", name, e, a);
    end
  endfunction

  initial begin
    int          i;
    int          nfr;
    logic [15:0] fc;
    hdr_pos        = '0;
    hdr_open       = 1'b0;
    fc_word        = '0;
    dpan_acc       = '0;
    daddr_acc      = '0;
    span_acc       = '0;
    saddr_acc      = '0;
    n_sent         = 0;
    n_mismatch     = 0;

    // stray byte while idle, dropped
    queue_byte(8'hFF, 1'b0, 1'b0);
    // frame cut after its first control byte, restarted by the next one
    queue_byte(8'h00, 1'b1, 1'b0);
    // both modes reserved, dest error takes priority
    queue_byte(8'h00, 1'b1, 1'b0);
    queue_byte(8'h44, 1'b0, 1'b0);
    // reserved source mode with extended dest
    queue_byte(8'hBF, 1'b1, 1'b0);
    queue_byte(8'h4C, 1'b0, 1'b0);
    // shortest header: no addresses at all
    queue_byte(8'h40, 1'b1, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'hA5, 1'b0, 1'b0);
    // compression with no dest: source pan id reads zero
    queue_byte(8'h40, 1'b1, 1'b0);
    queue_byte(8'h80, 1'b0, 1'b0);
    queue_byte(8'h5A, 1'b0, 1'b0);
    queue_byte(8'h34, 1'b0, 1'b0);
    queue_byte(8'h12, 1'b0, 1'b0);
    // longest header: both extended, no compression
    queue_byte(8'hBF, 1'b1, 1'b0);
    queue_byte(8'hCC, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    for (i = 0; i < 20; i++)
      queue_byte((i % 3 == 0) ? 8'hFF : 8'(i * 8'h25), 1'b0, 1'b0);

    nfr = 0;
    while (byte_q.size() < ITEM_TARGET) begin
      fc = 16'($urandom);
      fc[11:10] = pick_mode();
      fc[15:14] = pick_mode();
      add_frame(fc, (nfr % 120) == 60);
      if ($urandom_range(99) < 10) queue_byte(8'($urandom), 1'b0, 1'b0);
      nfr++;
    end
    n_total = byte_q.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (byte_q.size() != 0 || in_valid || header_exp_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_mismatch == 0 && header_exp_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // sender: present the queue head, pop it on acceptance
  always @(posedge clk) begin : drv
    logic busy;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        parse_header_byte(data_byte, frame_start);
        void'(byte_q.pop_front());
        n_sent++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (byte_q.size() != 0 && !(byte_q[0].drain && header_exp_q.size() != 0) &&
            $urandom_range(99) >= tx_idle_pct()) begin
          in_valid    <= 1'b1;
          data_byte   <= byte_q[0].data;
          frame_start <= byte_q[0].start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each result beat against the oldest expectation
  always @(posedge clk) begin : mon
    mhap_result_t exp_r;
    int           hold_left;
    bit           hold_done;
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (header_exp_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("result beat with nothing expected");
        end else begin
          exp_r = header_exp_q.pop_front();
          check_field("dest_mode", 64'(exp_r.dest_mode), 64'(dest_mode));
          check_field("dest_pan_id", 64'(exp_r.dest_pan_id), 64'(dest_pan_id));
          check_field("dest_short_addr", 64'(exp_r.dest_short_addr),
                      64'(dest_short_addr));
          check_field("dest_ext_addr", exp_r.dest_ext_addr, dest_ext_addr);
          check_field("src_mode", 64'(exp_r.src_mode), 64'(src_mode));
          check_field("src_pan_id", 64'(exp_r.src_pan_id), 64'(src_pan_id));
          check_field("src_short_addr", 64'(exp_r.src_short_addr),
                      64'(src_short_addr));
          check_field("src_ext_addr", exp_r.src_ext_addr, src_ext_addr);
          check_field("header_length", 64'(exp_r.header_length), 64'(header_length));
          check_field("error_code", 64'(exp_r.error_code), 64'(error_code));
        end
      end
      // one long back-pressure stretch once the sender stops idling
      if (!hold_done && n_sent >= 2 * n_total / 3) begin
        hold_left = LONG_HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct());
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst) begin
      stall_cnt <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

endmodule
